FILE: hdl/melody_tone_sequencer_macros.svh
// ----------------------------------------------------------------------------
// melody tone sequencer assertion macros
// shared concurrent assertion forms, clocked on clk, held off during reset
// ----------------------------------------------------------------------------
`ifndef MELODY_TONE_SEQUENCER_MACROS_SVH
`define MELODY_TONE_SEQUENCER_MACROS_SVH

// same-cycle implication
`define MTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// shared types, codes and the note table of the melody tone sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

  // melody length and table geometry
  localparam int NOTE_COUNT = 39;
  localparam int ROM_SLOTS  = 64;
  localparam int POS_W      = 6;
  localparam int BEATS_W    = 5;
  localparam int DIV_W      = 16;
  localparam int TEMPO_W    = 4;
  localparam int GATE_PCT_W = 7;
  localparam int LEN_W      = BEATS_W + TEMPO_W;
  localparam int PROD_W     = LEN_W + GATE_PCT_W;
  localparam int TIME_W     = 32;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT, exact for x < 2^16
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] RECIP_100 = 18'd167773;
  localparam int MUL_W       = PROD_W + RECIP_W;

  // configuration register indexes and reset values
  localparam logic CFG_TEMPO_SCALE  = 1'b0;
  localparam logic CFG_GATE_PERCENT = 1'b1;
  localparam logic [TEMPO_W-1:0]    TEMPO_RESET = 4'd3;
  localparam logic [GATE_PCT_W-1:0] GATE_RESET  = 7'd45;

  // request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_PROD,
    ST_DIV,
    ST_UPD
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic do_len;
    logic do_prod;
    logic do_div;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_valid;
  } dp_status_t;

  // one table entry: tone divisor (zero for a rest) and length in beats
  typedef struct packed {
    logic [DIV_W-1:0]   div;
    logic [BEATS_W-1:0] beats;
  } note_t;

  // tone divisors, 1193180 / hz
  localparam logic [DIV_W-1:0] D_A4 = 16'd2711;
  localparam logic [DIV_W-1:0] D_B4 = 16'd2415;
  localparam logic [DIV_W-1:0] D_C5 = 16'd2281;
  localparam logic [DIV_W-1:0] D_D5 = 16'd2032;
  localparam logic [DIV_W-1:0] D_E5 = 16'd1810;
  localparam logic [DIV_W-1:0] D_F5 = 16'd1709;
  localparam logic [DIV_W-1:0] D_G5 = 16'd1521;
  localparam logic [DIV_W-1:0] D_A5 = 16'd1355;
  localparam logic [DIV_W-1:0] D_REST = 16'd0;

  // melody; unused slots are zero-beat rests
  localparam note_t NOTE_ROM [ROM_SLOTS] = '{
    0:  '{D_E5, 5'd16}, 1:  '{D_B4, 5'd8},  2:  '{D_C5, 5'd8},
    3:  '{D_D5, 5'd16}, 4:  '{D_C5, 5'd8},  5:  '{D_B4, 5'd8},
    6:  '{D_A4, 5'd16}, 7:  '{D_A4, 5'd8},  8:  '{D_C5, 5'd8},
    9:  '{D_E5, 5'd16}, 10: '{D_D5, 5'd8},  11: '{D_C5, 5'd8},
    12: '{D_B4, 5'd24}, 13: '{D_C5, 5'd8},  14: '{D_D5, 5'd16},
    15: '{D_E5, 5'd16}, 16: '{D_C5, 5'd16}, 17: '{D_A4, 5'd16},
    18: '{D_A4, 5'd24}, 19: '{D_REST, 5'd8},
    20: '{D_D5, 5'd24}, 21: '{D_F5, 5'd8},  22: '{D_A5, 5'd16},
    23: '{D_G5, 5'd8},  24: '{D_F5, 5'd8},  25: '{D_E5, 5'd24},
    26: '{D_C5, 5'd8},  27: '{D_E5, 5'd16}, 28: '{D_D5, 5'd8},
    29: '{D_C5, 5'd8},  30: '{D_B4, 5'd16}, 31: '{D_B4, 5'd8},
    32: '{D_C5, 5'd8},  33: '{D_D5, 5'd16}, 34: '{D_E5, 5'd16},
    35: '{D_C5, 5'd16}, 36: '{D_A4, 5'd16}, 37: '{D_A4, 5'd24},
    38: '{D_REST, 5'd8},
    default: '{D_REST, 5'd0}
  };

endpackage

`default_nettype wire

FILE: hdl/melody_tone_sequencer.sv
// ----------------------------------------------------------------------------
// melody_tone_sequencer
// plays a fixed melody from a note table, driven by tick, start and stop words
// ----------------------------------------------------------------------------
// Each accepted input word produces exactly one output word. After acceptance
// the word passes through note lookup with the deadline compares, the length
// times gate multiply, the divide by 100 done as a reciprocal multiply, and
// the update of the sequencer state into the output register, which waits
// while that register still holds a word the output side has not taken.
// A new word is accepted in the cycle the previous result is committed, so
// the three chained multiply stages hold one word at a time. A finished word
// waits in the output register while the next input is taken. Configuration
// writes belong to idle periods only.
`timescale 1ns / 1ps
`default_nettype none

module melody_tone_sequencer (
  input  wire         clk,
  input  wire         rst_n,
  // configuration
  input  wire         cfg_wen,
  input  wire         cfg_index,
  input  wire  [6:0]  cfg_wdata,
  // input stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] now
  input  wire  [1:0]  in_tuser,   // [1:0] req_type
  // output stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata   // [0] speaker_enable, [1] load_divisor,
                                  // [17:2] divisor, [23:18] note_position
);
  import mts_pkg::*;

  ctrl_cmd_t          cmd;
  dp_status_t         status;
  logic               spk;
  logic               load;
  logic [DIV_W-1:0]   div;
  logic [POS_W-1:0]   pos;

  // controller
  mts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // datapath
  mts_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wen            (cfg_wen),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_req             (in_tuser),
    .in_now             (in_tdata),
    .cmd                (cmd),
    .status             (status),
    .out_tready         (out_tready),
    .out_tvalid         (out_tvalid),
    .out_speaker_enable (spk),
    .out_load_divisor   (load),
    .out_divisor        (div),
    .out_note_position  (pos)
  );

  // pack the output word
  assign out_tdata = {pos, div, load, spk};

endmodule

`default_nettype wire

FILE: hdl/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// sequencing state machine: accepts a word, walks it through the arithmetic
// stages and commits the result once the output register is free
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mts_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  input  wire                     out_tready,
  input  mts_pkg::dp_status_t     status,
  output mts_pkg::ctrl_cmd_t      cmd
);
  import mts_pkg::*;

  state_t state_r, state_nxt;
  logic   commit_ok;

  // result can move into the output register
  assign commit_ok = (state_r == ST_UPD) && (!status.out_valid || out_tready);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_LEN;
      end
      ST_LEN:  state_nxt = ST_PROD;
      ST_PROD: state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_UPD;
      ST_UPD: begin
        if (commit_ok) state_nxt = in_tvalid ? ST_LEN : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready   = (state_r == ST_IDLE) || commit_ok;
    cmd         = '0;
    cmd.load_in = in_tvalid && in_tready;
    cmd.do_len  = (state_r == ST_LEN);
    cmd.do_prod = (state_r == ST_PROD);
    cmd.do_div  = (state_r == ST_DIV);
    cmd.commit  = commit_ok;
  end

endmodule

`default_nettype wire

FILE: hdl/mts_datapath.sv
// ----------------------------------------------------------------------------
// mts_datapath
// note lookup, length and gate arithmetic, sequencer state and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mts_datapath (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_wen,
  input  wire                                 cfg_index,
  input  wire  [mts_pkg::GATE_PCT_W-1:0]      cfg_wdata,
  input  wire  [1:0]                          in_req,
  input  wire  [mts_pkg::TIME_W-1:0]          in_now,
  input  mts_pkg::ctrl_cmd_t                  cmd,
  output mts_pkg::dp_status_t                 status,
  input  wire                                 out_tready,
  output logic                                out_tvalid,
  output logic                                out_speaker_enable,
  output logic                                out_load_divisor,
  output logic [mts_pkg::DIV_W-1:0]           out_divisor,
  output logic [mts_pkg::POS_W-1:0]           out_note_position
);
  import mts_pkg::*;

  // configuration
  logic [TEMPO_W-1:0]    tempo_r;
  logic [GATE_PCT_W-1:0] gate_r;

  // sequencer state
  logic              playing_r, playing_nxt;
  logic              tone_on_r, tone_on_nxt;
  logic [TIME_W-1:0] next_time_r, next_time_nxt;
  logic [TIME_W-1:0] off_time_r, off_time_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;

  // word in flight
  logic [1:0]        req_r;
  logic [TIME_W-1:0] now_r;
  logic [DIV_W-1:0]  div_r;
  logic [LEN_W-1:0]  len_r;
  logic [PROD_W-1:0] prod_r;
  logic [LEN_W-1:0]  gated_r;
  logic              off_hit_r;
  logic              next_hit_r;

  // result register
  logic              out_valid_r;
  logic              spk_r;
  logic              load_r, load_nxt;
  logic [DIV_W-1:0]  odiv_r, odiv_nxt;

  note_t             note;
  logic [MUL_W-1:0]  recip_mul;
  logic [LEN_W-1:0]  quot;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_r <= TEMPO_RESET;
      gate_r  <= GATE_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_TEMPO_SCALE:  tempo_r <= cfg_wdata[TEMPO_W-1:0];
        CFG_GATE_PERCENT: gate_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // capture the incoming word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r <= in_req;
      now_r <= in_now;
    end
  end

  // note lookup, note length and deadline compares
  assign note = NOTE_ROM[pos_r];

  always_ff @(posedge clk) begin
    if (cmd.do_len) begin
      div_r      <= note.div;
      len_r      <= LEN_W'(note.beats) * LEN_W'(tempo_r);
      off_hit_r  <= (now_r >= off_time_r);
      next_hit_r <= (now_r >= next_time_r);
    end
  end

  // length times gate percent
  always_ff @(posedge clk) begin
    if (cmd.do_prod) begin
      prod_r <= PROD_W'(len_r) * PROD_W'(gate_r);
    end
  end

  // divide by 100 through the reciprocal, minimum of one tick
  assign recip_mul = MUL_W'(prod_r) * MUL_W'(RECIP_100);
  assign quot      = recip_mul[RECIP_SHIFT +: LEN_W];

  always_ff @(posedge clk) begin
    if (cmd.do_div) begin
      gated_r <= (quot == '0) ? LEN_W'(1) : quot;
    end
  end

  // state update on commit
  always_comb begin
    playing_nxt   = playing_r;
    tone_on_nxt   = tone_on_r;
    next_time_nxt = next_time_r;
    off_time_nxt  = off_time_r;
    pos_nxt       = pos_r;
    load_nxt      = 1'b0;
    odiv_nxt      = '0;
    unique case (req_r)
      REQ_START: begin
        playing_nxt   = 1'b1;
        tone_on_nxt   = 1'b0;
        next_time_nxt = '0;
        off_time_nxt  = '0;
        pos_nxt       = '0;
      end
      REQ_STOP: begin
        playing_nxt = 1'b0;
        tone_on_nxt = 1'b0;
      end
      REQ_TICK: begin
        if (playing_r) begin
          if (tone_on_r && off_hit_r) tone_on_nxt = 1'b0;
          if (next_hit_r) begin
            off_time_nxt  = now_r + TIME_W'(gated_r);
            next_time_nxt = now_r + TIME_W'(len_r);
            pos_nxt = (pos_r == POS_W'(NOTE_COUNT - 1)) ? '0 : pos_r + POS_W'(1);
            // a rest silences, a real note sounds and loads its divisor
            if (div_r == '0) begin
              tone_on_nxt = 1'b0;
            end else begin
              tone_on_nxt = 1'b1;
              load_nxt    = 1'b1;
              odiv_nxt    = div_r;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r   <= 1'b0;
      tone_on_r   <= 1'b0;
      next_time_r <= '0;
      off_time_r  <= '0;
      pos_r       <= '0;
    end else if (cmd.commit) begin
      playing_r   <= playing_nxt;
      tone_on_r   <= tone_on_nxt;
      next_time_r <= next_time_nxt;
      off_time_r  <= off_time_nxt;
      pos_r       <= pos_nxt;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      spk_r  <= tone_on_nxt;
      load_r <= load_nxt;
      odiv_r <= odiv_nxt;
    end
  end

  assign status.out_valid   = out_valid_r;
  assign out_tvalid         = out_valid_r;
  assign out_speaker_enable = spk_r;
  assign out_load_divisor   = load_r;
  assign out_divisor        = odiv_r;
  assign out_note_position  = pos_r;

endmodule

`default_nettype wire

FILE: hdl/mts_checker.sv
// ----------------------------------------------------------------------------
// mts_checker
// port-level checks of the melody tone sequencer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "melody_tone_sequencer_macros.svh"

module mts_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [23:0] out_tdata
);
  import mts_pkg::*;

  // a stalled output word holds
  `MTS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output word changed while stalled")

  // a loaded divisor is a real tone and sounds
  `MTS_ASSERT_IMPL(a_load_sounds, out_tvalid && out_tdata[1], out_tdata[0] && (out_tdata[17:2] != '0), "divisor load without tone")

  // no load means a zero divisor field
  `MTS_ASSERT_IMPL(a_noload_zero, out_tvalid && !out_tdata[1], out_tdata[17:2] == '0, "divisor set without load")

  // position stays inside the melody
  `MTS_ASSERT_IMPL(a_pos_range, out_tvalid, out_tdata[23:18] < POS_W'(NOTE_COUNT), "note position out of range")

  // after taking a word the block is busy with it
  `MTS_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready right after accept")

endmodule

bind melody_tone_sequencer mts_checker u_mts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

FILE: tb/sv/tb_melody_tone_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_melody_tone_sequencer
// self-checking bench for the melody tone sequencer: tick, start and stop
// words go in on the input stream, and every output word is checked against
// an in-bench model of the note sequencing, gating and divisor issue
// ----------------------------------------------------------------------------
module tb_melody_tone_sequencer;
  import mts_pkg::*;

  localparam int HALF_PERIOD_NS = 5;
  localparam int CYCLE_LIMIT    = 300000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int unsigned TONE_CLOCK_HZ = 1193180;

  // request code with no meaning to the block
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // melody: tone frequency in hz (zero is a rest) and length in beats
  localparam int unsigned MELODY_HZ [NOTE_COUNT] = '{
    659, 494, 523, 587, 523, 494, 440, 440, 523, 659, 587, 523,
    494, 523, 587, 659, 523, 440, 440, 0,
    587, 698, 880, 784, 698, 659, 523, 659, 587, 523,
    494, 494, 523, 587, 659, 523, 440, 440, 0
  };
  localparam int unsigned MELODY_BEATS [NOTE_COUNT] = '{
    16, 8, 8, 16, 8, 8, 16, 8, 8, 16, 8, 8,
    24, 8, 16, 16, 16, 16, 24, 8,
    24, 8, 16, 8, 8, 24, 8, 16, 8, 8,
    16, 8, 8, 16, 16, 16, 16, 24, 8
  };

  // output word, laid out as on out_tdata
  typedef struct packed {
    logic [5:0]  note_pos;
    logic [15:0] tone_div;
    logic        div_load;
    logic        spk_enable;
  } tone_word_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_wen    = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [6:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [31:0] now
  logic [1:0]  in_tuser   = '0;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [0] speaker_enable, [1] load_divisor,
                                  // [17:2] divisor, [23:18] note_position

  // sequencer model state and its copy of the registers
  logic                  play_active;
  logic                  tone_active;
  logic [31:0]           next_note_at;
  logic [31:0]           tone_off_at;
  logic [5:0]            note_idx;
  logic [TEMPO_W-1:0]    tempo_q;
  logic [GATE_PCT_W-1:0] gate_q;

  tone_word_t  pending_tone_words[$];
  int unsigned err_count      = 0;
  int unsigned cycle_count    = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;

  melody_tone_sequencer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(HALF_PERIOD_NS) clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // random backpressure on the result side
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // compare each result word with the oldest expected one
  always @(posedge clk) begin
    tone_word_t got;
    tone_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_tone_words.size() == 0) begin
        $error("unexpected word 0x%06h with nothing pending", out_tdata);
        err_count++;
      end else begin
        want = pending_tone_words.pop_front();
        if (got.spk_enable !== want.spk_enable) begin
          $error("speaker_enable: expected %0d, got %0d", want.spk_enable, got.spk_enable);
          err_count++;
        end
        if (got.div_load !== want.div_load) begin
          $error("load_divisor: expected %0d, got %0d", want.div_load, got.div_load);
          err_count++;
        end
        if (got.tone_div !== want.tone_div) begin
          $error("divisor: expected %0d, got %0d", want.tone_div, got.tone_div);
          err_count++;
        end
        if (got.note_pos !== want.note_pos) begin
          $error("note_position: expected %0d, got %0d", want.note_pos, got.note_pos);
          err_count++;
        end
      end
    end
  end

  // reset values of the sequencer and its registers
  task automatic reset_melody_model();
    tempo_q      = TEMPO_W'(3);
    gate_q       = GATE_PCT_W'(45);
    play_active  = 1'b0;
    tone_active  = 1'b0;
    next_note_at = '0;
    tone_off_at  = '0;
    note_idx     = '0;
  endtask

  // advance the sequencer by one request and return the word it reports
  function automatic tone_word_t step_melody(input logic [1:0] req, input logic [31:0] stamp);
    tone_word_t  w;
    int unsigned note_len;
    int unsigned sound_len;
    w = '0;
    case (req)
      REQ_START: begin
        play_active  = 1'b1;
        tone_active  = 1'b0;
        next_note_at = '0;
        tone_off_at  = '0;
        note_idx     = '0;
      end
      REQ_STOP: begin
        play_active = 1'b0;
        tone_active = 1'b0;
      end
      REQ_TICK: begin
        if (play_active) begin
          // gate the tone off first, then look at the next-note deadline
          if (tone_active && stamp >= tone_off_at)
            tone_active = 1'b0;
          if (stamp >= next_note_at) begin
            note_len  = MELODY_BEATS[note_idx] * int'(tempo_q);
            sound_len = note_len * int'(gate_q) / 100;
            if (sound_len == 0)
              sound_len = 1;
            if (MELODY_HZ[note_idx] == 0) begin
              tone_active = 1'b0;
            end else begin
              w.div_load  = 1'b1;
              w.tone_div  = 16'(TONE_CLOCK_HZ / MELODY_HZ[note_idx]);
              tone_active = 1'b1;
            end
            tone_off_at  = stamp + 32'(sound_len);
            next_note_at = stamp + 32'(note_len);
            note_idx     = (note_idx == 6'(NOTE_COUNT - 1)) ? '0 : note_idx + 6'd1;
          end
        end
      end
      default: ;
    endcase
    w.spk_enable = tone_active;
    w.note_pos   = note_idx;
    return w;
  endfunction

  // hand one word to the block, with a random idle gap in front of it
  task automatic send_word(input logic [1:0] req, input logic [31:0] stamp);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= stamp;
    do @(posedge clk); while (!in_tready);
    pending_tone_words.push_back(step_melody(req, stamp));
  endtask

  // stop sending and wait for every pending result
  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_tone_words.size() != 0)
      @(posedge clk);
  endtask

  // both registers are written only with the block idle
  task automatic configure_idle(input int unsigned tempo, input int unsigned gate);
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= CFG_TEMPO_SCALE;
    cfg_wdata <= 7'(tempo & 'hF);
    @(posedge clk);
    tempo_q   = TEMPO_W'(tempo);
    cfg_index <= CFG_GATE_PERCENT;
    cfg_wdata <= 7'(gate);
    @(posedge clk);
    gate_q    = GATE_PCT_W'(gate);
    cfg_wen   <= 1'b0;
    @(posedge clk);
  endtask

  // stopped block ignores ticks; unused code reports unchanged state
  task automatic test_stopped_and_unused();
    send_word(REQ_TICK, 32'd0);
    send_word(REQ_UNUSED, 32'hFFFF_FFFF);
    send_word(REQ_STOP, 32'h5555_AAAA);
    send_word(REQ_TICK, 32'd123);
  endtask

  // first notes at reset tempo and gate, gate-off edge, stop keeps position
  task automatic test_first_notes_and_gating();
    send_word(REQ_START, 32'hAAAA_5555);
    send_word(REQ_TICK, 32'd0);
    send_word(REQ_TICK, 32'd20);
    send_word(REQ_TICK, 32'd21);
    send_word(REQ_TICK, 32'd48);
    send_word(REQ_STOP, 32'd0);
    send_word(REQ_TICK, 32'd100);
  endtask

  // deadlines that wrap past 2^32 compare as plain unsigned values
  task automatic test_time_wraparound();
    send_word(REQ_START, 32'd0);
    send_word(REQ_TICK, 32'hFFFF_FFF0);
    send_word(REQ_TICK, 32'hFFFF_FFF1);
    send_word(REQ_TICK, 32'hFFFF_FFFF);
  endtask

  // zero tempo: zero-length notes, every tick loads the next one
  task automatic test_zero_tempo_and_gate();
    configure_idle(0, 0);
    send_word(REQ_START, 32'd7);
    send_word(REQ_TICK, 32'd5);
    send_word(REQ_TICK, 32'd5);
    send_word(REQ_TICK, 32'd6);
  endtask

  // gate above 100 lets the tone run into the following note
  task automatic test_gate_over_hundred();
    configure_idle(15, 127);
    send_word(REQ_START, 32'd0);
    send_word(REQ_TICK, 32'd1000);
    send_word(REQ_TICK, 32'd1240);
    send_word(REQ_TICK, 32'd1304);
  endtask

  // mostly start-then-ticks runs with rising time, plus random noise words
  task automatic run_melody_traffic(input int unsigned n_words);
    int unsigned sent;
    int unsigned run_len;
    int unsigned max_step;
    logic [31:0] clock_now;
    sent     = 0;
    max_step = int'(tempo_q) * 10 + 3;
    while (sent < n_words) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(2'($urandom_range(0, 3)), $urandom());
        sent++;
      end else begin
        if ($urandom_range(0, 3) == 0)
          clock_now = 32'hFFFF_FFFF - $urandom_range(0, 400);
        else
          clock_now = $urandom();
        send_word(REQ_START, $urandom());
        sent++;
        run_len = $urandom_range(5, 60);
        for (int unsigned k = 0; k < run_len && sent < n_words; k++) begin
          clock_now += $urandom_range(0, max_step);
          send_word(REQ_TICK, clock_now);
          sent++;
        end
        if (sent < n_words && $urandom_range(0, 1) == 1) begin
          send_word(REQ_STOP, $urandom());
          sent++;
        end
      end
    end
  endtask

  // one random phase at fixed settings; sender drains once halfway
  task automatic test_traffic_phase(input int unsigned tempo, input int unsigned gate,
                                    input int unsigned src_pct, input int unsigned sink_pct,
                                    input int unsigned n_words);
    configure_idle(tempo, gate);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    run_melody_traffic(n_words / 2);
    pause_until_drained();
    run_melody_traffic(n_words - n_words / 2);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  initial begin
    reset_melody_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_stopped_and_unused();
    test_first_notes_and_gating();
    test_time_wraparound();
    test_zero_tempo_and_gate();
    test_gate_over_hundred();

    test_traffic_phase(1, 100, 0, 0, 300);
    test_traffic_phase(15, 0, 52, 0, 300);
    test_traffic_phase(0, 127, 0, 52, 300);
    test_traffic_phase($urandom_range(0, 15), $urandom_range(0, 127), 34, 34, 250);
    test_traffic_phase(7, 50, 0, 0, 200);

    pause_until_drained();
    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
